// ----- rtl/core/ubx_frame_parser_core_macros.svh -----
// Assertion helpers for the UBX parser checker
`ifndef UBX_FRAME_PARSER_CORE_MACROS_SVH
`define UBX_FRAME_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define UBXP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ubx parser check failed");

// next-cycle implication
`define UBXP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ubx parser check failed");

`endif

// ----- rtl/core/ubxp_pkg.sv -----
package ubxp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  localparam logic [3:0] ROLE_NONE    = 4'd0;
  localparam logic [3:0] ROLE_SYNC1   = 4'd1;
  localparam logic [3:0] ROLE_SYNC2   = 4'd2;
  localparam logic [3:0] ROLE_CLASS   = 4'd3;
  localparam logic [3:0] ROLE_ID      = 4'd4;
  localparam logic [3:0] ROLE_LENLO   = 4'd5;
  localparam logic [3:0] ROLE_LENHI   = 4'd6;
  localparam logic [3:0] ROLE_PAYLOAD = 4'd7;
  localparam logic [3:0] ROLE_CK      = 4'd8;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_SYNC  = 2'd1;
  localparam logic [1:0] ERR_CKSUM = 2'd2;

  localparam int QUEUE_DEPTH_DEF = 2;

  // tagged byte handed from the front end to the checksum back end
  typedef struct packed {
    logic [7:0]  byte_value;
    logic [3:0]  byte_role;
    logic [15:0] payload_index;
    logic        frame_done;
    logic        sync_err;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
  } ubxp_rec_t;

endpackage

// ----- rtl/core/ubxp_if.sv -----
interface ubxp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxp_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [3:0]  byte_role;
  logic [15:0] payload_index;
  logic        frame_done;
  logic        frame_valid;
  logic [7:0]  msg_class;
  logic [7:0]  msg_id;
  logic [15:0] payload_length;
  logic [1:0]  error_kind;

  modport source (output valid, output byte_value, output byte_role, output payload_index,
                  output frame_done, output frame_valid, output msg_class, output msg_id,
                  output payload_length, output error_kind, input ready);
  modport sink   (input valid, input byte_value, input byte_role, input payload_index,
                  input frame_done, input frame_valid, input msg_class, input msg_id,
                  input payload_length, input error_kind, output ready);
endinterface

// ----- rtl/core/ubx_frame_parser_core.sv -----
// UBX frame parser: one result per received byte, in order.
// Throughput: one byte per cycle sustained unless the output stalls; front end
//   keeps taking bytes while a result waits, until the byte queue (QUEUE_DEPTH
//   entries) is full. Each record passes the queue, then the result register.
// Reset: synchronous active-low rst_n clears the parse phase, checksum sums,
//   queue pointers and output valid; hunting for sync starts right after.
module ubx_frame_parser_core
  import ubxp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ubxp_byte_if.sink     in_ch,
  ubxp_result_if.source out_ch
);

  logic      f_valid, f_ready;
  ubxp_rec_t f_rec;
  logic      q_valid, q_ready;
  ubxp_rec_t q_rec;

  ubxp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.rx_byte),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec       (f_rec)
  );

  ubxp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_rec),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_rec)
  );

  ubxp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec_valid          (q_valid),
    .rec_ready          (q_ready),
    .rec                (q_rec),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_byte_value     (out_ch.byte_value),
    .out_byte_role      (out_ch.byte_role),
    .out_payload_index  (out_ch.payload_index),
    .out_frame_done     (out_ch.frame_done),
    .out_frame_valid    (out_ch.frame_valid),
    .out_msg_class      (out_ch.msg_class),
    .out_msg_id         (out_ch.msg_id),
    .out_payload_length (out_ch.payload_length),
    .out_error_kind     (out_ch.error_kind)
  );

endmodule

// ----- rtl/core/ubxp_fifo.sv -----
module ubxp_fifo
  import ubxp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  ubxp_rec_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output ubxp_rec_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  ubxp_rec_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/ubxp_front.sv -----
module ubxp_front
  import ubxp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       rec_valid,
  input  logic       rec_ready,
  output ubxp_rec_t  rec
);

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_SYNC2 = 4'd1,
    PH_CLASS = 4'd2,
    PH_ID    = 4'd3,
    PH_LENLO = 4'd4,
    PH_LENHI = 4'd5,
    PH_DATA  = 4'd6,
    PH_CKA   = 4'd7,
    PH_CKB   = 4'd8
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  cls_r, cls_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        take;

  assign rec_valid = in_valid;
  assign in_ready  = rec_ready;
  assign take      = in_valid && rec_ready;

  always_comb begin
    rec            = '0;
    rec.byte_value = in_byte;
    phase_nxt      = phase_r;
    cls_nxt        = cls_r;
    id_nxt         = id_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    unique case (phase_r)
      PH_SYNC2: begin
        if (in_byte == SYNC_SECOND) begin
          rec.byte_role = ROLE_SYNC2;
          phase_nxt     = PH_CLASS;
        end else begin
          // a bad second sync byte may itself start a new frame
          rec.sync_err = 1'b1;
          if (in_byte == SYNC_FIRST) begin
            rec.byte_role = ROLE_SYNC1;
            phase_nxt     = PH_SYNC2;
          end else begin
            rec.byte_role = ROLE_NONE;
            phase_nxt     = PH_HUNT;
          end
        end
      end
      PH_CLASS: begin
        rec.byte_role = ROLE_CLASS;
        cls_nxt       = in_byte;
        rec.msg_class = in_byte;
        phase_nxt     = PH_ID;
      end
      PH_ID: begin
        rec.byte_role = ROLE_ID;
        id_nxt        = in_byte;
        rec.msg_class = cls_r;
        rec.msg_id    = in_byte;
        phase_nxt     = PH_LENLO;
      end
      PH_LENLO: begin
        rec.byte_role      = ROLE_LENLO;
        len_nxt            = {8'h00, in_byte};
        rec.msg_class      = cls_r;
        rec.msg_id         = id_r;
        rec.payload_length = {8'h00, in_byte};
        phase_nxt          = PH_LENHI;
      end
      PH_LENHI: begin
        rec.byte_role      = ROLE_LENHI;
        len_nxt            = {in_byte, len_r[7:0]};
        cnt_nxt            = '0;
        rec.msg_class      = cls_r;
        rec.msg_id         = id_r;
        rec.payload_length = {in_byte, len_r[7:0]};
        phase_nxt          = (len_nxt == '0) ? PH_CKA : PH_DATA;
      end
      PH_DATA: begin
        rec.byte_role      = ROLE_PAYLOAD;
        rec.payload_index  = cnt_r;
        cnt_nxt            = cnt_r + 16'd1;
        rec.msg_class      = cls_r;
        rec.msg_id         = id_r;
        rec.payload_length = len_r;
        if (cnt_nxt == len_r) begin
          phase_nxt = PH_CKA;
        end
      end
      PH_CKA: begin
        rec.byte_role      = ROLE_CK;
        rec.msg_class      = cls_r;
        rec.msg_id         = id_r;
        rec.payload_length = len_r;
        phase_nxt          = PH_CKB;
      end
      PH_CKB: begin
        rec.byte_role      = ROLE_CK;
        rec.frame_done     = 1'b1;
        rec.msg_class      = cls_r;
        rec.msg_id         = id_r;
        rec.payload_length = len_r;
        phase_nxt          = PH_HUNT;
      end
      default: begin
        if (in_byte == SYNC_FIRST) begin
          rec.byte_role = ROLE_SYNC1;
          phase_nxt     = PH_SYNC2;
        end else begin
          rec.byte_role = ROLE_NONE;
          phase_nxt     = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cls_r   <= '0;
      id_r    <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cls_r   <= cls_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/ubxp_back.sv -----
module ubxp_back
  import ubxp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rec_valid,
  output logic        rec_ready,
  input  ubxp_rec_t   rec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_value,
  output logic [3:0]  out_byte_role,
  output logic [15:0] out_payload_index,
  output logic        out_frame_done,
  output logic        out_frame_valid,
  output logic [7:0]  out_msg_class,
  output logic [7:0]  out_msg_id,
  output logic [15:0] out_payload_length,
  output logic [1:0]  out_error_kind
);

  logic       vld_r;
  ubxp_rec_t  res_r;
  logic       fval_r, fval_nxt;
  logic [1:0] err_r, err_nxt;
  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;
  logic [7:0] ck_a_r, ck_a_nxt;
  logic       pop;

  assign rec_ready = !vld_r || out_ready;
  assign pop       = rec_valid && rec_ready;

  always_comb begin
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    ck_a_nxt  = ck_a_r;
    fval_nxt  = 1'b0;
    err_nxt   = rec.sync_err ? ERR_SYNC : ERR_NONE;
    case (rec.byte_role) inside
      ROLE_SYNC2: begin
        sum_a_nxt = '0;
        sum_b_nxt = '0;
      end
      ROLE_CLASS, ROLE_ID, ROLE_LENLO, ROLE_LENHI, ROLE_PAYLOAD: begin
        sum_a_nxt = sum_a_r + rec.byte_value;
        sum_b_nxt = sum_b_r + sum_a_nxt;
      end
      ROLE_CK: begin
        if (!rec.frame_done) begin
          ck_a_nxt = rec.byte_value;
        end else if (ck_a_r == sum_a_r && rec.byte_value == sum_b_r) begin
          fval_nxt = 1'b1;
        end else begin
          err_nxt = ERR_CKSUM;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r  <= rec;
      fval_r <= fval_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      ck_a_r  <= '0;
    end else begin
      if (pop) begin
        vld_r   <= 1'b1;
        sum_a_r <= sum_a_nxt;
        sum_b_r <= sum_b_nxt;
        ck_a_r  <= ck_a_nxt;
      end else if (out_ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  assign out_valid          = vld_r;
  assign out_byte_value     = res_r.byte_value;
  assign out_byte_role      = res_r.byte_role;
  assign out_payload_index  = res_r.payload_index;
  assign out_frame_done     = res_r.frame_done;
  assign out_frame_valid    = fval_r;
  assign out_msg_class      = res_r.msg_class;
  assign out_msg_id         = res_r.msg_id;
  assign out_payload_length = res_r.payload_length;
  assign out_error_kind     = err_r;

endmodule

// ----- rtl/core/ubxp_checker.sv -----
`include "ubx_frame_parser_core_macros.svh"

module ubxp_checker
  import ubxp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  byte_value,
  input logic [3:0]  byte_role,
  input logic [15:0] payload_index,
  input logic        frame_done,
  input logic        frame_valid,
  input logic [1:0]  error_kind
);

  `UBXP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(byte_value))
  `UBXP_ASSERT_NOW(a_valid_on_done, out_valid && frame_valid, frame_done && error_kind == ERR_NONE)
  `UBXP_ASSERT_NOW(a_done_is_ck, out_valid && frame_done, byte_role == ROLE_CK)
  `UBXP_ASSERT_NOW(a_cksum_err, out_valid && error_kind == ERR_CKSUM, frame_done && !frame_valid)
  `UBXP_ASSERT_NOW(a_idx_payload, out_valid && byte_role != ROLE_PAYLOAD, payload_index == '0)

endmodule

bind ubx_frame_parser_core ubxp_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .byte_value    (out_ch.byte_value),
  .byte_role     (out_ch.byte_role),
  .payload_index (out_ch.payload_index),
  .frame_done    (out_ch.frame_done),
  .frame_valid   (out_ch.frame_valid),
  .error_kind    (out_ch.error_kind)
);

// ----- dv/tb_ubx_frame_parser_core.sv -----
module tb_ubx_frame_parser_core;
  import ubxp_pkg::*;

  typedef enum logic [3:0] {
    PH_HUNT, PH_WAIT_SYNC2, PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI,
    PH_PAYLOAD, PH_CK_A, PH_CK_B
  } parse_ph_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [3:0]  byte_role;
    logic [15:0] payload_index;
    logic        frame_done;
    logic        frame_valid;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [1:0]  error_kind;
  } parse_result_t;

  typedef struct {
    logic [7:0]    rx;
    bit            typed;
    parse_result_t want;
  } dir_row_t;

  logic clk;
  logic rst_n = 1'b0;

  ubxp_byte_if   in_if();
  ubxp_result_if out_if();

  ubx_frame_parser_core uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // predictor state
  parse_ph_t   parse_ph  = PH_HUNT;
  logic [7:0]  cap_class = '0;
  logic [7:0]  cap_id    = '0;
  logic [15:0] cap_len   = '0;
  logic [15:0] pay_count = '0;
  logic [7:0]  sum_a     = '0;
  logic [7:0]  sum_b     = '0;
  logic [7:0]  ck_a_rx   = '0;

  // running checksum of the frame being built by the stimulus
  logic [7:0]  gen_a, gen_b;

  parse_result_t pending_results[$];
  dir_row_t      dir_rows[$];
  int            mismatch_count = 0;
  int            sent_count     = 0;
  int            result_count   = 0;
  logic [7:0]    last_tx        = '0;
  bit            in_quiet       = 1'b0;
  bit            out_quiet      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void fletcher_add(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  function automatic parse_result_t predict_byte(input logic [7:0] b);
    parse_result_t r;
    r = '0;
    r.byte_value = b;
    case (parse_ph)
      PH_WAIT_SYNC2: begin
        if (b == SYNC_SECOND) begin
          r.byte_role = ROLE_SYNC2;
          sum_a = '0;
          sum_b = '0;
          cap_class = '0;
          cap_id = '0;
          cap_len = '0;
          pay_count = '0;
          parse_ph = PH_CLASS;
        end else begin
          // a bad second sync byte may itself open a new frame
          r.error_kind = ERR_SYNC;
          if (b == SYNC_FIRST) begin
            r.byte_role = ROLE_SYNC1;
            parse_ph = PH_WAIT_SYNC2;
          end else begin
            r.byte_role = ROLE_NONE;
            parse_ph = PH_HUNT;
          end
        end
      end
      PH_CLASS: begin
        r.byte_role = ROLE_CLASS;
        cap_class = b;
        fletcher_add(b);
        r.msg_class = cap_class;
        parse_ph = PH_ID;
      end
      PH_ID: begin
        r.byte_role = ROLE_ID;
        cap_id = b;
        fletcher_add(b);
        r.msg_class = cap_class;
        r.msg_id = cap_id;
        parse_ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        r.byte_role = ROLE_LENLO;
        cap_len = {8'h00, b};
        fletcher_add(b);
        r.msg_class = cap_class;
        r.msg_id = cap_id;
        r.payload_length = cap_len;
        parse_ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        r.byte_role = ROLE_LENHI;
        cap_len[15:8] = b;
        fletcher_add(b);
        pay_count = '0;
        r.msg_class = cap_class;
        r.msg_id = cap_id;
        r.payload_length = cap_len;
        parse_ph = (cap_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        r.byte_role = ROLE_PAYLOAD;
        r.payload_index = pay_count;
        fletcher_add(b);
        pay_count = pay_count + 16'd1;
        r.msg_class = cap_class;
        r.msg_id = cap_id;
        r.payload_length = cap_len;
        if (pay_count == cap_len) parse_ph = PH_CK_A;
      end
      PH_CK_A: begin
        r.byte_role = ROLE_CK;
        ck_a_rx = b;
        r.msg_class = cap_class;
        r.msg_id = cap_id;
        r.payload_length = cap_len;
        parse_ph = PH_CK_B;
      end
      PH_CK_B: begin
        r.byte_role = ROLE_CK;
        r.frame_done = 1'b1;
        r.msg_class = cap_class;
        r.msg_id = cap_id;
        r.payload_length = cap_len;
        if (ck_a_rx == sum_a && b == sum_b) r.frame_valid = 1'b1;
        else r.error_kind = ERR_CKSUM;
        // no rescan of the failed frame
        parse_ph = PH_HUNT;
      end
      default: begin
        if (b == SYNC_FIRST) begin
          r.byte_role = ROLE_SYNC1;
          parse_ph = PH_WAIT_SYNC2;
        end else begin
          r.byte_role = ROLE_NONE;
          parse_ph = PH_HUNT;
        end
      end
    endcase
    return r;
  endfunction

  function automatic parse_result_t typed_result(
    input logic [7:0] v, input logic [3:0] role, input logic done, input logic ok,
    input logic [7:0] cls, input logic [7:0] mid, input logic [15:0] len,
    input logic [1:0] err);
    parse_result_t r;
    r = '0;
    r.byte_value = v;
    r.byte_role = role;
    r.frame_done = done;
    r.frame_valid = ok;
    r.msg_class = cls;
    r.msg_id = mid;
    r.payload_length = len;
    r.error_kind = err;
    return r;
  endfunction

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch on transaction %0d, %s: got %0h want %0h",
             result_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input parse_result_t want);
    if (out_if.byte_value !== want.byte_value)
      report("byte_value", int'(out_if.byte_value), int'(want.byte_value));
    if (out_if.byte_role !== want.byte_role)
      report("byte_role", int'(out_if.byte_role), int'(want.byte_role));
    if (out_if.payload_index !== want.payload_index)
      report("payload_index", int'(out_if.payload_index), int'(want.payload_index));
    if (out_if.frame_done !== want.frame_done)
      report("frame_done", int'(out_if.frame_done), int'(want.frame_done));
    if (out_if.frame_valid !== want.frame_valid)
      report("frame_valid", int'(out_if.frame_valid), int'(want.frame_valid));
    if (out_if.msg_class !== want.msg_class)
      report("msg_class", int'(out_if.msg_class), int'(want.msg_class));
    if (out_if.msg_id !== want.msg_id)
      report("msg_id", int'(out_if.msg_id), int'(want.msg_id));
    if (out_if.payload_length !== want.payload_length)
      report("payload_length", int'(out_if.payload_length), int'(want.payload_length));
    if (out_if.error_kind !== want.error_kind)
      report("error_kind", int'(out_if.error_kind), int'(want.error_kind));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) report("unexpected transaction", 1, 0);
      else check_result(pending_results.pop_front());
      result_count++;
    end
  end

  // result side: random stalls, with quiet stretches
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) < 2) out_quiet = ~out_quiet;
      gap = draw_gap(out_quiet);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input parse_result_t want = '0);
    int gap;
    parse_result_t p;
    if ($urandom_range(0, 99) < 2) in_quiet = ~in_quiet;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      in_if.rx_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    p = predict_byte(b);
    pending_results.push_back(typed ? want : p);
    last_tx = b;
    sent_count++;
  endtask

  task automatic send_summed(input logic [7:0] b);
    send_byte(b);
    gen_a = gen_a + b;
    gen_b = gen_b + gen_a;
  endtask

  task automatic send_frame(input bit corrupt);
    int sel;
    int n;
    logic [7:0] ck_a, ck_b, mask;
    sel = $urandom_range(0, 99);
    if (sel < 85) n = $urandom_range(0, 12);
    else if (sel < 97) n = $urandom_range(13, 40);
    else n = $urandom_range(256, 300);
    gen_a = '0;
    gen_b = '0;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_summed(8'($urandom));
    send_summed(8'($urandom));
    send_summed(n[7:0]);
    send_summed(n[15:8]);
    for (int i = 0; i < n; i++) send_summed(8'($urandom));
    ck_a = gen_a;
    ck_b = gen_b;
    if (corrupt) begin
      mask = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 1)) ck_a = ck_a ^ mask;
      else ck_b = ck_b ^ mask;
    end
    send_byte(ck_a);
    send_byte(ck_b);
  endtask

  task automatic send_bad_sync();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == SYNC_SECOND) b = ~b;
    send_byte(SYNC_FIRST);
    send_byte(b);
  endtask

  // line noise; never forms a sync pair, so no frame of random length starts
  task automatic send_noise();
    int n;
    logic [7:0] b;
    n = $urandom_range(1, 6);
    repeat (n) begin
      b = 8'($urandom);
      if (last_tx == SYNC_FIRST && b == SYNC_SECOND) b = 8'h00;
      send_byte(b);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic add_row(input logic [7:0] b, input bit typed = 1'b0,
                         input parse_result_t want = '0);
    dir_row_t row;
    row.rx = b;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  initial begin
    int start;
    int kind;
    in_if.valid <= 1'b0;
    in_if.rx_byte <= 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // hunting, sync handling, zero-length frame with good checksum
    add_row(8'h00, 1'b1, typed_result(8'h00, ROLE_NONE, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0,
                                      ERR_NONE));
    add_row(8'hFF, 1'b1, typed_result(8'hFF, ROLE_NONE, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0,
                                      ERR_NONE));
    add_row(8'hB5, 1'b1, typed_result(8'hB5, ROLE_SYNC1, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0,
                                      ERR_NONE));
    add_row(8'h00, 1'b1, typed_result(8'h00, ROLE_NONE, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0,
                                      ERR_SYNC));
    add_row(8'hB5, 1'b1, typed_result(8'hB5, ROLE_SYNC1, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0,
                                      ERR_NONE));
    add_row(8'hB5, 1'b1, typed_result(8'hB5, ROLE_SYNC1, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0,
                                      ERR_SYNC));
    add_row(8'h62, 1'b1, typed_result(8'h62, ROLE_SYNC2, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0,
                                      ERR_NONE));
    add_row(8'hFF, 1'b1, typed_result(8'hFF, ROLE_CLASS, 1'b0, 1'b0, 8'hFF, 8'h00, 16'h0,
                                      ERR_NONE));
    add_row(8'h00, 1'b1, typed_result(8'h00, ROLE_ID, 1'b0, 1'b0, 8'hFF, 8'h00, 16'h0,
                                      ERR_NONE));
    add_row(8'h00);
    add_row(8'h00);
    add_row(8'hFF);
    add_row(8'hFC, 1'b1, typed_result(8'hFC, ROLE_CK, 1'b1, 1'b1, 8'hFF, 8'h00, 16'h0,
                                      ERR_NONE));
    // two-byte payload, bad checksum, then no rescan
    add_row(8'hB5);
    add_row(8'h62);
    add_row(8'h01);
    add_row(8'hFF);
    add_row(8'h02);
    add_row(8'h00);
    add_row(8'h80);
    add_row(8'h7F);
    add_row(8'h00);
    add_row(8'h00, 1'b1, typed_result(8'h00, ROLE_CK, 1'b1, 1'b0, 8'h01, 8'hFF, 16'h2,
                                      ERR_CKSUM));
    add_row(8'h62, 1'b1, typed_result(8'h62, ROLE_NONE, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0,
                                      ERR_NONE));

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    start = sent_count;
    while (sent_count - start < 1150) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) send_frame(1'b0);
      else if (kind < 80) send_frame(1'b1);
      else if (kind < 90) send_bad_sync();
      else send_noise();
      if ($urandom_range(0, 24) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
